// ----- rtl/core/bsfg_pkg.sv -----
package bsfg_pkg;

  localparam int unsigned TablePoints = 21;
  localparam int unsigned IdxW        = $clog2(TablePoints);

  localparam int unsigned MvW   = 16;
  localparam int unsigned PctW  = 7;
  localparam int unsigned CapW  = 16;
  localparam int unsigned CurW  = 16;
  localparam int unsigned FailW = 4;
  localparam int unsigned MinW  = 22;
  localparam int unsigned DivW  = CapW + PctW;
  localparam int unsigned DenW  = CurW + 1;

  localparam int unsigned PaddrW = 5;

  // open-circuit voltage curve, ascending
  localparam logic [MvW-1:0] OcvMv [TablePoints] = '{
    16'd3000, 16'd3410, 16'd3490, 16'd3580, 16'd3610, 16'd3630, 16'd3650,
    16'd3680, 16'd3700, 16'd3730, 16'd3760, 16'd3790, 16'd3820, 16'd3870,
    16'd3920, 16'd3970, 16'd4020, 16'd4080, 16'd4110, 16'd4150, 16'd4200
  };
  localparam logic [PctW-1:0] OcvPct [TablePoints] = '{
    7'd0,  7'd5,  7'd10, 7'd15, 7'd20, 7'd25, 7'd30,
    7'd35, 7'd40, 7'd45, 7'd50, 7'd55, 7'd60, 7'd65,
    7'd70, 7'd75, 7'd80, 7'd85, 7'd90, 7'd95, 7'd100
  };

  localparam logic [PctW-1:0] FullPct        = 7'd100;
  localparam logic [PctW-1:0] MinutesPerHour = 7'd60;

  typedef enum logic [1:0] {
    LevelOk       = 2'd0,
    LevelLow      = 2'd1,
    LevelCritical = 2'd2
  } level_e;

  localparam logic [2:0] RegPresent  = 3'd0;
  localparam logic [2:0] RegLowThr   = 3'd1;
  localparam logic [2:0] RegCritThr  = 3'd2;
  localparam logic [2:0] RegFaultThr = 3'd3;
  localparam logic [2:0] RegCapacity = 3'd4;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DenW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/core/bsfg_div.sv -----
module bsfg_div import bsfg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DivW);

  logic [DivW-1:0] quo_q;
  logic [DenW-1:0] rem_q;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;

  logic [DenW:0]   shifted;
  logic            fits;
  logic [DenW-1:0] rem_next;

  // restoring division, one quotient bit per cycle
  assign shifted  = {rem_q, quo_q[DivW-1]};
  assign fits     = shifted >= {1'b0, den_q};
  assign rem_next = fits ? DenW'(shifted - {1'b0, den_q}) : shifted[DenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(DivW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivW-2:0], fits};
      rem_q <= rem_next;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ----- rtl/core/battery_soc_fuel_gauge.sv -----
// a good read inside the table runs the segment search, then an interpolating divide;
// clamped voltages go straight to the level step, failed reads and absent devices to the
// minutes step; nonzero held current adds two divides (capacity share, then minutes)
// a full output register stalls the sequencer before it loads the result
// one poll at a time: the next transfer can come in the cycle after the result is loaded
// reset (async, active low) clears held state and sets registers to their defaults
module battery_soc_fuel_gauge import bsfg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PaddrW-1:0]       paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,

  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    read_ok_i,
  input  logic [MvW-1:0]          voltage_mv_i,
  input  logic signed [CurW-1:0]  current_ma_i,

  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [PctW-1:0]         charge_pct_o,
  output logic [1:0]              battery_level_o,
  output logic                    read_fault_o,
  output logic [MinW-1:0]         minutes_left_o
);

  typedef enum logic [9:0] {
    StIdle   = 10'b0000000001,
    StSearch = 10'b0000000010,
    StInterp = 10'b0000000100,
    StSocDiv = 10'b0000001000,
    StLevel  = 10'b0000010000,
    StCapMul = 10'b0000100000,
    StMahDiv = 10'b0001000000,
    StMinMul = 10'b0010000000,
    StMinDiv = 10'b0100000000,
    StDone   = 10'b1000000000
  } state_e;

  localparam logic [IdxW-1:0] SegLast = IdxW'(TablePoints - 2);

  // configuration
  logic             present_q;
  logic [PctW-1:0]  low_thr_q;
  logic [PctW-1:0]  crit_thr_q;
  logic [FailW-1:0] fault_thr_q;
  logic [CapW-1:0]  cap_q;
  logic             cfg_wr;

  state_e           state_q, state_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [FailW-1:0] fail_q, fail_d;
  logic [PctW-1:0]  charge_q, charge_d;
  level_e           level_q, level_d;
  logic [CurW-1:0]  cur_q, cur_d;
  logic [MvW-1:0]   mv_q, mv_d;
  logic [MinW-1:0]  minutes_q, minutes_d;

  logic             out_valid_q, out_valid_d;
  logic [PctW-1:0]  out_charge_q, out_charge_d;
  logic [1:0]       out_level_q, out_level_d;
  logic             out_fault_q, out_fault_d;
  logic [MinW-1:0]  out_minutes_q, out_minutes_d;

  logic [FailW-1:0] eff_thr;
  logic [IdxW-1:0]  idx_nx;
  logic [MvW-1:0]   lo_mv, hi_mv, span_mv;
  logic [PctW-1:0]  lo_pct, hi_pct, pct_rise;
  logic             in_seg;
  logic             discharging;
  logic [PctW-1:0]  charge_span;
  logic [DenW-1:0]  mag;

  logic [CapW-1:0]  mul_a;
  logic [PctW-1:0]  mul_b;
  logic [DivW-1:0]  mul_p;

  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= 1'b0;
      low_thr_q   <= 7'd10;
      crit_thr_q  <= 7'd3;
      fault_thr_q <= 4'd3;
      cap_q       <= 16'd17500;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        RegPresent:  present_q   <= pwdata[0];
        RegLowThr:   low_thr_q   <= pwdata[PctW-1:0];
        RegCritThr:  crit_thr_q  <= pwdata[PctW-1:0];
        RegFaultThr: fault_thr_q <= pwdata[FailW-1:0];
        RegCapacity: cap_q       <= pwdata[CapW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RegPresent:  prdata = {31'b0, present_q};
      RegLowThr:   prdata = {25'b0, low_thr_q};
      RegCritThr:  prdata = {25'b0, crit_thr_q};
      RegFaultThr: prdata = {28'b0, fault_thr_q};
      RegCapacity: prdata = {16'b0, cap_q};
      default:     prdata = '0;
    endcase
  end

  assign eff_thr = (fault_thr_q == '0) ? FailW'(1) : fault_thr_q;

  // current table segment
  assign idx_nx   = idx_q + IdxW'(1);
  assign lo_mv    = OcvMv[idx_q];
  assign hi_mv    = OcvMv[idx_nx];
  assign lo_pct   = OcvPct[idx_q];
  assign hi_pct   = OcvPct[idx_nx];
  assign span_mv  = hi_mv - lo_mv;
  assign pct_rise = (hi_pct >= lo_pct) ? hi_pct - lo_pct : '0;
  assign in_seg   = (mv_q >= lo_mv) && (mv_q <= hi_mv);

  assign discharging = ~cur_q[CurW-1];
  assign charge_span = discharging ? charge_q : FullPct - charge_q;
  assign mag         = discharging ? {1'b0, cur_q} : {1'b1, {CurW{1'b0}}} - {1'b0, cur_q};

  // shared multiplier, product goes straight into the divider registers
  assign mul_p = DivW'(mul_a) * DivW'(mul_b);

  bsfg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    fail_d        = fail_q;
    charge_d      = charge_q;
    level_d       = level_q;
    cur_d         = cur_q;
    mv_d          = mv_q;
    minutes_d     = minutes_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    out_charge_d  = out_charge_q;
    out_level_d   = out_level_q;
    out_fault_d   = out_fault_q;
    out_minutes_d = out_minutes_q;
    mul_a         = '0;
    mul_b         = '0;
    div_req       = '0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          mv_d    = voltage_mv_i;
          state_d = StCapMul;
          if (present_q) begin
            if (!read_ok_i) begin
              if (fail_q < eff_thr) fail_d = fail_q + FailW'(1);
            end else begin
              fail_d = '0;
              cur_d  = current_ma_i;
              idx_d  = '0;
              if (voltage_mv_i <= OcvMv[0]) begin
                charge_d = OcvPct[0];
                state_d  = StLevel;
              end else if (voltage_mv_i >= OcvMv[TablePoints-1]) begin
                charge_d = OcvPct[TablePoints-1];
                state_d  = StLevel;
              end else begin
                state_d = StSearch;
              end
            end
          end
        end
      end
      StSearch: begin
        if (in_seg) begin
          if (span_mv == '0) begin
            // flat segment takes the lower point
            charge_d = lo_pct;
            state_d  = StLevel;
          end else begin
            state_d = StInterp;
          end
        end else if (idx_q == SegLast) begin
          charge_d = '0;
          state_d  = StLevel;
        end else begin
          idx_d = idx_nx;
        end
      end
      StInterp: begin
        mul_a            = mv_q - lo_mv;
        mul_b            = pct_rise;
        div_req.start    = 1'b1;
        div_req.dividend = mul_p;
        div_req.divisor  = {1'b0, span_mv};
        state_d          = StSocDiv;
      end
      StSocDiv: begin
        if (div_rsp.done) begin
          charge_d = lo_pct + div_rsp.quotient[PctW-1:0];
          state_d  = StLevel;
        end
      end
      StLevel: begin
        if (charge_q <= crit_thr_q) level_d = LevelCritical;
        else if (charge_q <= low_thr_q) level_d = LevelLow;
        else level_d = LevelOk;
        state_d = StCapMul;
      end
      StCapMul: begin
        if (cur_q == '0) begin
          minutes_d = '0;
          state_d   = StDone;
        end else begin
          // capacity times charge (or headroom), then divide by full scale
          mul_a            = cap_q;
          mul_b            = charge_span;
          div_req.start    = 1'b1;
          div_req.dividend = mul_p;
          div_req.divisor  = DenW'(FullPct);
          state_d          = StMahDiv;
        end
      end
      StMahDiv: begin
        if (div_rsp.done) state_d = StMinMul;
      end
      StMinMul: begin
        mul_a            = div_rsp.quotient[CapW-1:0];
        mul_b            = MinutesPerHour;
        div_req.start    = 1'b1;
        div_req.dividend = mul_p;
        div_req.divisor  = mag;
        state_d          = StMinDiv;
      end
      StMinDiv: begin
        if (div_rsp.done) begin
          minutes_d = div_rsp.quotient[MinW-1:0];
          state_d   = StDone;
        end
      end
      StDone: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          out_charge_d  = charge_q;
          out_level_d   = level_q;
          out_fault_d   = fail_q >= eff_thr;
          out_minutes_d = minutes_q;
          state_d       = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      fail_q      <= '0;
      charge_q    <= '0;
      level_q     <= LevelOk;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      fail_q      <= fail_d;
      charge_q    <= charge_d;
      level_q     <= level_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mv_q          <= mv_d;
    minutes_q     <= minutes_d;
    out_charge_q  <= out_charge_d;
    out_level_q   <= out_level_d;
    out_fault_q   <= out_fault_d;
    out_minutes_q <= out_minutes_d;
  end

  assign in_ready_o      = (state_q == StIdle);
  assign out_valid_o     = out_valid_q;
  assign charge_pct_o    = out_charge_q;
  assign battery_level_o = out_level_q;
  assign read_fault_o    = out_fault_q;
  assign minutes_left_o  = out_minutes_q;

endmodule

// ----- verif/testbench.sv -----
module testbench;
  import bsfg_pkg::*;

  localparam int unsigned CurvePoints = 21;
  localparam int unsigned QuietLimit  = 5000;
  localparam int unsigned SettleWait  = 120;
  localparam int unsigned HoldOffLen  = 300;

  // open-circuit voltage curve kept here so the gauge's own table is checked too
  localparam int unsigned CurveMv [CurvePoints] = '{
    3000, 3410, 3490, 3580, 3610, 3630, 3650, 3680, 3700, 3730, 3760,
    3790, 3820, 3870, 3920, 3970, 4020, 4080, 4110, 4150, 4200
  };
  localparam int unsigned CurvePct [CurvePoints] = '{
    0, 5, 10, 15, 20, 25, 30, 35, 40, 45, 50,
    55, 60, 65, 70, 75, 80, 85, 90, 95, 100
  };

  typedef struct {
    logic [PctW-1:0] charge;
    level_e          level;
    logic            fault;
    logic [MinW-1:0] minutes;
  } gauge_report_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [PaddrW-1:0] paddr        = '0;
  logic [31:0]       pwdata       = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic              read_ok_i    = 1'b0;
  logic [MvW-1:0]    voltage_mv_i = '0;
  logic signed [CurW-1:0] current_ma_i = '0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic [PctW-1:0]   charge_pct_o;
  logic [1:0]        battery_level_o;
  logic              read_fault_o;
  logic [MinW-1:0]   minutes_left_o;

  battery_soc_fuel_gauge dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .read_ok_i       (read_ok_i),
    .voltage_mv_i    (voltage_mv_i),
    .current_ma_i    (current_ma_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .charge_pct_o    (charge_pct_o),
    .battery_level_o (battery_level_o),
    .read_fault_o    (read_fault_o),
    .minutes_left_o  (minutes_left_o)
  );

  // gauge state and register copies
  int unsigned     cfg_present, cfg_low, cfg_crit, cfg_fault_thr, cfg_capacity;
  logic [PctW-1:0] held_charge;
  logic [CurW-1:0] held_current;
  int unsigned     fails;
  level_e          held_level;

  gauge_report_t pending_reports [$];
  int unsigned   mismatches, reports_checked, polls_sent, failed_polls, reg_writes;
  int unsigned   burst_left, stall_len, quiet_cycles;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [PctW-1:0] charge_from_voltage(input logic [MvW-1:0] mv);
    int unsigned v, num;
    v = mv;
    if (v <= CurveMv[0]) return PctW'(CurvePct[0]);
    if (v >= CurveMv[CurvePoints-1]) return PctW'(CurvePct[CurvePoints-1]);
    for (int i = 0; i < CurvePoints - 1; i++) begin
      if (v >= CurveMv[i] && v <= CurveMv[i+1]) begin
        // flat segment keeps the lower point
        if (CurveMv[i+1] == CurveMv[i]) return PctW'(CurvePct[i]);
        num = (v - CurveMv[i]) * (CurvePct[i+1] - CurvePct[i]);
        return PctW'(CurvePct[i] + num / (CurveMv[i+1] - CurveMv[i]));
      end
    end
    return '0;
  endfunction

  function automatic logic [MinW-1:0] minutes_remaining();
    int unsigned mag, mah, pct;
    pct = held_charge;
    if (held_current == '0) return '0;
    if (!held_current[CurW-1]) begin
      mag = held_current;
      mah = cfg_capacity * pct / 100;
    end else begin
      // charging: time to full
      mag = 32'h1_0000 - {16'd0, held_current};
      mah = cfg_capacity * (100 - pct) / 100;
    end
    return MinW'((mah * 60) / mag);
  endfunction

  function automatic void advance_gauge(input logic ok, input logic [MvW-1:0] mv,
                                        input logic [CurW-1:0] ma);
    gauge_report_t r;
    int unsigned   thr;
    thr = (cfg_fault_thr == 0) ? 1 : cfg_fault_thr;
    if (cfg_present != 0) begin
      if (!ok) begin
        if (fails < thr) fails++;
      end else begin
        fails        = 0;
        held_current = ma;
        held_charge  = charge_from_voltage(mv);
        if (held_charge <= cfg_crit) held_level = LevelCritical;
        else if (held_charge <= cfg_low) held_level = LevelLow;
        else held_level = LevelOk;
      end
    end
    r.charge  = held_charge;
    r.level   = held_level;
    r.fault   = (fails >= thr);
    r.minutes = minutes_remaining();
    pending_reports.push_back(r);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegPresent:  cfg_present   = value[0];
      RegLowThr:   cfg_low       = value[6:0];
      RegCritThr:  cfg_crit      = value[6:0];
      RegFaultThr: cfg_fault_thr = value[3:0];
      RegCapacity: cfg_capacity  = value[15:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic set_limits(input int unsigned low, input int unsigned crit,
                            input int unsigned fault_thr, input int unsigned capacity);
    write_reg(RegLowThr, low);
    write_reg(RegCritThr, crit);
    write_reg(RegFaultThr, fault_thr);
    write_reg(RegCapacity, capacity);
  endtask

  task automatic send_poll(input logic ok, input logic [MvW-1:0] mv,
                           input logic [CurW-1:0] ma);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    read_ok_i    <= ok;
    voltage_mv_i <= mv;
    current_ma_i <= ma;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_gauge(ok, mv, ma);
    polls_sent++;
    if (!ok) failed_polls++;
  endtask

  // lets every outstanding report arrive before registers change
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic [CurW-1:0] pick_current();
    int m;
    case ($urandom_range(0, 9))
      0: return '0;
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0001;
          default: return 16'hFFFF;
        endcase
      end
      2, 3, 4, 5: begin
        m = $urandom_range(1, 5000);
        return $urandom_range(0, 1) ? CurW'(-m) : CurW'(m);
      end
      default: return CurW'($urandom);
    endcase
  endfunction

  function automatic logic [MvW-1:0] pick_voltage();
    case ($urandom_range(0, 9))
      0: return MvW'($urandom);
      1: return $urandom_range(0, 1) ? MvW'($urandom_range(0, 3000))
                                     : MvW'($urandom_range(4200, 65535));
      2, 3: return MvW'(CurveMv[$urandom_range(0, CurvePoints-1)] + $urandom_range(0, 2) - 1);
      default: return MvW'($urandom_range(3000, 4200));
    endcase
  endfunction

  task automatic random_polls(input int unsigned count);
    int unsigned sent, run;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        // a streak of failed reads, at times long enough to saturate the largest threshold
        0, 1: begin
          run = $urandom_range(1, 18);
          repeat (run) send_poll(1'b0, MvW'($urandom), CurW'($urandom));
          sent += run;
        end
        default: begin
          send_poll(1'b1, pick_voltage(), pick_current());
          sent++;
        end
      endcase
    end
  endtask

  task automatic test_absent_device();
    send_poll(1'b1, 16'd3700, 16'd1000);
    send_poll(1'b0, 16'd0, 16'd0);
    send_poll(1'b1, 16'hFFFF, 16'h8000);
    wait_idle();
    write_reg(RegPresent, 1);
    set_limits(10, 3, 3, 17500);
  endtask

  task automatic test_table_edges();
    send_poll(1'b1, 16'd0,    16'h7FFF);
    send_poll(1'b1, 16'd2999, 16'hFFFF);
    send_poll(1'b1, 16'd3000, 16'h0001);
    send_poll(1'b1, 16'd3001, 16'h8000);
    send_poll(1'b1, 16'd3409, 16'd0);
    send_poll(1'b1, 16'd3410, 16'hFE0C);
    send_poll(1'b1, 16'd3455, 16'd1234);
    send_poll(1'b1, 16'd4199, 16'd2500);
    send_poll(1'b1, 16'd4200, 16'hFFFF);
    send_poll(1'b1, 16'd4201, 16'd700);
    send_poll(1'b1, 16'hFFFF, 16'hF000);
  endtask

  task automatic test_fault_saturation();
    repeat (4) send_poll(1'b0, 16'hFFFF, 16'h7FFF);
    // absent device freezes state but still reports the held fault
    wait_idle();
    write_reg(RegPresent, 0);
    send_poll(1'b1, 16'd3800, 16'd500);
    wait_idle();
    write_reg(RegPresent, 1);
    send_poll(1'b1, 16'd3800, 16'd0);
  endtask

  task automatic test_threshold_corners();
    wait_idle();
    set_limits(127, 0, 0, 17500);
    send_poll(1'b1, 16'd3000, 16'd100);
    send_poll(1'b1, 16'd3760, 16'd100);
    send_poll(1'b0, 16'd3760, 16'd100);
    wait_idle();
    set_limits(0, 127, 15, 0);
    send_poll(1'b1, 16'd4200, 16'd1);
    wait_idle();
    write_reg(RegCapacity, 65535);
    send_poll(1'b1, 16'd4200, 16'd1);
    send_poll(1'b1, 16'd3000, 16'hFFFF);
  endtask

  task automatic test_backpressure();
    stall_len  = HoldOffLen;
    burst_left = 30;
    repeat (12) send_poll(1'b1, pick_voltage(), pick_current());
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 7; p++) begin
      wait_idle();
      case (p)
        0: set_limits(10, 3, 3, 17500);
        1: set_limits(0, 0, 1, 0);
        2: set_limits(127, 127, 15, 65535);
        default: set_limits($urandom_range(0, 127), $urandom_range(0, 127),
                            $urandom_range(0, 15), $urandom_range(0, 65535));
      endcase
      random_polls(145);
      if (p == 4) begin
        wait_idle();
        write_reg(RegPresent, 0);
        random_polls(15);
        wait_idle();
        write_reg(RegPresent, 1);
      end
    end
  endtask

  // receiver: picks a new stall pattern for each span of random length
  initial begin : receiver
    int unsigned mode, span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 64);
      for (int unsigned c = 0; c < span; c++) begin
        @(posedge clk_i);
        if (stall_len != 0) begin
          out_ready_i <= 1'b0;
          stall_len--;
        end else begin
          case (mode)
            0: out_ready_i <= 1'b1;
            1: out_ready_i <= $urandom_range(0, 1);
            2: out_ready_i <= ($urandom_range(0, 3) == 0);
            default: out_ready_i <= (c % 8 == 7);
          endcase
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_reports
    gauge_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: report transfer with nothing pending (charge %0d)",
                 $time, charge_pct_o);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (charge_pct_o !== want.charge) begin
          $display("%0t: charge_pct expected %0d actual %0d", $time, want.charge,
                   charge_pct_o);
          mismatches++;
        end
        if (battery_level_o !== want.level) begin
          $display("%0t: battery_level expected %0d actual %0d", $time, want.level,
                   battery_level_o);
          mismatches++;
        end
        if (read_fault_o !== want.fault) begin
          $display("%0t: read_fault expected %0d actual %0d", $time, want.fault,
                   read_fault_o);
          mismatches++;
        end
        if (minutes_left_o !== want.minutes) begin
          $display("%0t: minutes_left expected %0d actual %0d", $time, want.minutes,
                   minutes_left_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d reports outstanding", $time,
               quiet_cycles, pending_reports.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_present   = 0;
    cfg_low       = 10;
    cfg_crit      = 3;
    cfg_fault_thr = 3;
    cfg_capacity  = 17500;
    held_charge   = '0;
    held_current  = '0;
    fails         = 0;
    held_level    = LevelOk;
    mismatches    = 0;
    reports_checked = 0;
    polls_sent    = 0;
    failed_polls  = 0;
    reg_writes    = 0;
    burst_left    = 0;
    stall_len     = 0;
    quiet_cycles  = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_absent_device();
    test_table_edges();
    test_fault_saturation();
    test_threshold_corners();
    test_backpressure();
    test_random_settings();

    wait_idle();
    repeat (SettleWait) @(posedge clk_i);
    $display("polls sent %0d (%0d failed reads), reports checked %0d, register writes %0d",
             polls_sent, failed_polls, reports_checked, reg_writes);
    $display("covered table ends and segments, fault saturation, frozen device, extreme %s",
             "thresholds and capacity, and a long output stall");
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- battery_soc_fuel_gauge.f -----
rtl/core/bsfg_pkg.sv
rtl/core/bsfg_div.sv
rtl/core/battery_soc_fuel_gauge.sv
verif/testbench.sv
